>>> design/gpp_pkg.sv
// Shared types and constants for the GPIO port register block.
// Holds the command codes, register offsets and the request/result structs.
// No dependencies.
package gpp_pkg;

    localparam int unsigned NUM_PINS = 16;

    // Command codes of one request
    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_PIN   = 2'd2;

    // Only full-word bus accesses are taken
    localparam logic [3:0] WORD_SIZE = 4'd4;

    // Register map, byte offsets within the port
    localparam logic [11:0] OFS_MODE  = 12'h000;
    localparam logic [11:0] OFS_OTYPE = 12'h004;
    localparam logic [11:0] OFS_SPEED = 12'h008;
    localparam logic [11:0] OFS_PULL  = 12'h00C;
    localparam logic [11:0] OFS_IDR   = 12'h010;
    localparam logic [11:0] OFS_ODR   = 12'h014;
    localparam logic [11:0] OFS_BSRR  = 12'h018;
    localparam logic [11:0] OFS_LOCK  = 12'h01C;
    localparam logic [11:0] OFS_AFL   = 12'h020;
    localparam logic [11:0] OFS_AFH   = 12'h024;
    localparam logic [11:0] OFS_BRR   = 12'h028;

    // Two-bit mode and pull codes used by the input logic
    localparam logic [1:0] MODE_OUTPUT = 2'd1;
    localparam logic [1:0] PULL_UP     = 2'd1;

    localparam logic [31:0] MODE_RESET = 32'hFFFF_FFFF;

    // One request as it sits in the input register
    typedef struct packed {
        logic [1:0]  cmd;
        logic [11:0] offset;
        logic [3:0]  access_size;
        logic [31:0] write_data;
        logic        clock_on;
        logic [4:0]  pin;
        logic        pin_driven;
        logic        pin_high;
    } item_t;

    // One result as it sits in the output register
    typedef struct packed {
        logic        ok;
        logic [31:0] read_data;
        logic [15:0] pins_driving;
        logic [15:0] pins_level;
    } result_t;

endpackage

>>> design/gpio_port_register_block.sv
// Top level of the 16-pin GPIO port register block.
// Holds the request and result registers; depends on gpp_pkg and gpp_regfile.
//
// Usage:
//   Requests enter on the s_ channel (valid/ready): a bus read, a bus write
//   or an external pin-drive event. Each request produces exactly one result
//   on the m_ channel (valid/ready) carrying the accept flag, the read data
//   and the per-pin drive and level words after the request's update.
//   A request accepted on s_ is held in the request register, decoded from
//   it by gpp_regfile and captured in the result register, from which its
//   result is offered on m_; a stall on m_ can hold it in the request register.
//   Throughput: one request per cycle while m_ready keeps the result slot
//   free, set by the single decode-and-update pass between the two registers.
//   When the receiver stalls, the result register holds and the request
//   register fills; s_ready drops only when both are occupied, and rises in
//   the same cycle that m_ready frees the result slot.
//   Reset (aresetn low at a clock edge) empties both registers and returns
//   every port register to its reset value: all pins in analog mode, all
//   other registers and the external pin masks cleared.
module gpio_port_register_block (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [11:0] s_offset,
    input  logic [3:0]  s_access_size,
    input  logic [31:0] s_write_data,
    input  logic        s_clock_on,
    input  logic [4:0]  s_pin,
    input  logic        s_pin_driven,
    input  logic        s_pin_high,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_ok,
    output logic [31:0] m_read_data,
    output logic [15:0] m_pins_driving,
    output logic [15:0] m_pins_level
);
    import gpp_pkg::*;

    item_t   item_reg;
    logic    in_valid_reg;
    result_t res;
    result_t res_reg;
    logic    out_valid_reg;
    logic    advance;

    // A request moves on when the result slot is free or being emptied.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Request register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.cmd         <= s_cmd;
            item_reg.offset      <= s_offset;
            item_reg.access_size <= s_access_size;
            item_reg.write_data  <= s_write_data;
            item_reg.clock_on    <= s_clock_on;
            item_reg.pin         <= s_pin;
            item_reg.pin_driven  <= s_pin_driven;
            item_reg.pin_high    <= s_pin_high;
        end
    end

    gpp_regfile u_regfile (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (advance),
        .item    (item_reg),
        .res     (res)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_ok           = res_reg.ok;
    assign m_read_data    = res_reg.read_data;
    assign m_pins_driving = res_reg.pins_driving;
    assign m_pins_level   = res_reg.pins_level;

endmodule

>>> design/gpp_regfile.sv
// Register file and access logic of the GPIO port.
// Decodes one request, updates the port registers and forms the result.
// Depends on gpp_pkg.
module gpp_regfile (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              fire,
    input  gpp_pkg::item_t    item,
    output gpp_pkg::result_t  res
);
    import gpp_pkg::*;

    logic [31:0] mode_reg, mode_next;
    logic [15:0] out_type_reg, out_type_next;
    logic [31:0] speed_reg, speed_next;
    logic [31:0] pull_reg, pull_next;
    logic [15:0] out_data_reg, out_data_next;
    logic [31:0] lock_reg, lock_next;
    logic [31:0] alt_lo_reg, alt_lo_next;
    logic [31:0] alt_hi_reg, alt_hi_next;
    logic [15:0] ext_driven_reg, ext_driven_next;
    logic [15:0] ext_level_reg, ext_level_next;

    logic [15:0] input_word;
    logic [15:0] drive_next;
    logic        access_bad;
    logic [15:0] pin_bit;

    // Input data word, pin by pin: output mode, then external drive, then pull-up.
    always_comb begin
        for (int p = 0; p < NUM_PINS; p++) begin
            if (mode_reg[2*p +: 2] == MODE_OUTPUT) begin
                input_word[p] = out_data_reg[p];
            end else if (ext_driven_reg[p]) begin
                input_word[p] = ext_level_reg[p];
            end else begin
                input_word[p] = (pull_reg[2*p +: 2] == PULL_UP);
            end
        end
    end

    assign access_bad = (item.access_size != WORD_SIZE) || (item.offset[1:0] != 2'b00);
    assign pin_bit    = 16'd1 << item.pin[3:0];

    // Request decode, register update and result forming.
    always_comb begin
        mode_next       = mode_reg;
        out_type_next   = out_type_reg;
        speed_next      = speed_reg;
        pull_next       = pull_reg;
        out_data_next   = out_data_reg;
        lock_next       = lock_reg;
        alt_lo_next     = alt_lo_reg;
        alt_hi_next     = alt_hi_reg;
        ext_driven_next = ext_driven_reg;
        ext_level_next  = ext_level_reg;
        res.ok          = 1'b0;
        res.read_data   = 32'd0;

        case (item.cmd)
            CMD_READ: begin
                if (!access_bad) begin
                    if (!item.clock_on) begin
                        res.ok = 1'b1;
                    end else begin
                        res.ok = 1'b1;
                        case (item.offset)
                            OFS_MODE:  res.read_data = mode_reg;
                            OFS_OTYPE: res.read_data = {16'd0, out_type_reg};
                            OFS_SPEED: res.read_data = speed_reg;
                            OFS_PULL:  res.read_data = pull_reg;
                            OFS_IDR:   res.read_data = {16'd0, input_word};
                            OFS_ODR:   res.read_data = {16'd0, out_data_reg};
                            OFS_BSRR:  res.read_data = 32'd0;
                            OFS_LOCK:  res.read_data = lock_reg;
                            OFS_AFL:   res.read_data = alt_lo_reg;
                            OFS_AFH:   res.read_data = alt_hi_reg;
                            OFS_BRR:   res.read_data = 32'd0;
                            default:   res.ok = 1'b0;
                        endcase
                    end
                end
            end
            CMD_WRITE: begin
                if (!access_bad) begin
                    if (!item.clock_on) begin
                        res.ok = 1'b1;
                    end else begin
                        res.ok = 1'b1;
                        case (item.offset)
                            OFS_MODE:  mode_next     = item.write_data;
                            OFS_OTYPE: out_type_next = item.write_data[15:0];
                            OFS_SPEED: speed_next    = item.write_data;
                            OFS_PULL:  pull_next     = item.write_data;
                            OFS_ODR:   out_data_next = item.write_data[15:0];
                            OFS_BSRR:  out_data_next = (out_data_reg | item.write_data[15:0])
                                                       & ~item.write_data[31:16];
                            OFS_LOCK:  lock_next     = item.write_data;
                            OFS_AFL:   alt_lo_next   = item.write_data;
                            OFS_AFH:   alt_hi_next   = item.write_data;
                            OFS_BRR:   out_data_next = out_data_reg & ~item.write_data[15:0];
                            default:   res.ok = 1'b0;
                        endcase
                    end
                end
            end
            CMD_PIN: begin
                res.ok = 1'b1;
                // Pins above the port width are acknowledged and dropped.
                if (item.pin < 5'(NUM_PINS)) begin
                    ext_driven_next = item.pin_driven ? (ext_driven_reg | pin_bit)
                                                      : (ext_driven_reg & ~pin_bit);
                    ext_level_next  = item.pin_high ? (ext_level_reg | pin_bit)
                                                    : (ext_level_reg & ~pin_bit);
                end
            end
            default: begin
                res.ok = 1'b0;
            end
        endcase

        // Pin drive status is taken after this request's update.
        for (int p = 0; p < NUM_PINS; p++) begin
            drive_next[p] = (mode_next[2*p +: 2] == MODE_OUTPUT);
        end
        res.pins_driving = item.clock_on ? drive_next : 16'd0;
        res.pins_level   = out_data_next;
    end

    // Port registers, updated once per processed request.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_RESET;
            out_type_reg   <= '0;
            speed_reg      <= '0;
            pull_reg       <= '0;
            out_data_reg   <= '0;
            lock_reg       <= '0;
            alt_lo_reg     <= '0;
            alt_hi_reg     <= '0;
            ext_driven_reg <= '0;
            ext_level_reg  <= '0;
        end else if (fire) begin
            mode_reg       <= mode_next;
            out_type_reg   <= out_type_next;
            speed_reg      <= speed_next;
            pull_reg       <= pull_next;
            out_data_reg   <= out_data_next;
            lock_reg       <= lock_next;
            alt_lo_reg     <= alt_lo_next;
            alt_hi_reg     <= alt_hi_next;
            ext_driven_reg <= ext_driven_next;
            ext_level_reg  <= ext_level_next;
        end
    end

    // A pin event is always acknowledged.
    a_pin_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && item.cmd == CMD_PIN |-> res.ok)
        else $error("pin event not acknowledged");

    // A refused access returns no data.
    a_refused_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && !res.ok |-> res.read_data == 32'd0)
        else $error("refused access returned data");

    // Without a processed request the output data register holds.
    a_odr_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !fire |=> $stable(out_data_reg))
        else $error("output data changed without a request");

    // A gated clock never reports driving pins.
    a_gated_drive: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && !item.clock_on |-> res.pins_driving == 16'd0)
        else $error("pins driving with clock gated");

    // A gated-clock request leaves the output data register alone.
    a_gated_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && !item.clock_on && item.cmd != CMD_PIN |=> $stable(out_data_reg))
        else $error("output data changed with clock gated");

endmodule

>>> bench/tb.sv
// Self-checking testbench for the 16-pin GPIO port register block.
// Sends bus reads, bus writes and pin events, predicts each result and compares it.
// Depends on gpp_pkg and gpio_port_register_block.
`timescale 1ns / 1ps

module tb;
    import gpp_pkg::*;

    // The one command code the package leaves undefined
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic m_ready = 1'b0;
    item_t req = '0;
    logic s_ready;
    logic m_valid;
    logic m_ok;
    logic [31:0] m_read_data;
    logic [15:0] m_pins_driving;
    logic [15:0] m_pins_level;

    // Shadow copy of the port registers, kept in step with accepted requests
    logic [31:0] mode_q = MODE_RESET;
    logic [15:0] otype_q = '0;
    logic [31:0] speed_q = '0;
    logic [31:0] pull_q = '0;
    logic [15:0] odr_q = '0;
    logic [31:0] lock_q = '0;
    logic [31:0] afl_q = '0;
    logic [31:0] afh_q = '0;
    logic [15:0] ext_drv_q = '0;
    logic [15:0] ext_lvl_q = '0;

    result_t port_results[$];
    int mismatch_count = 0;
    bit idle_on = 1'b1;
    int long_hold = 0;

    gpio_port_register_block uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_cmd(req.cmd),
        .s_offset(req.offset),
        .s_access_size(req.access_size),
        .s_write_data(req.write_data),
        .s_clock_on(req.clock_on),
        .s_pin(req.pin),
        .s_pin_driven(req.pin_driven),
        .s_pin_high(req.pin_high),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_ok(m_ok),
        .m_read_data(m_read_data),
        .m_pins_driving(m_pins_driving),
        .m_pins_level(m_pins_level)
    );

    always #5 aclk = ~aclk;

    // Apply one request to the shadow registers and return the result it should give.
    function automatic result_t gpio_predict(input item_t it);
        result_t r;
        logic [31:0] rd;
        logic [15:0] idr_word;
        logic hit;
        int p;
        r = '0;
        rd = '0;
        idr_word = '0;
        hit = 1'b1;
        if (it.cmd == CMD_READ || it.cmd == CMD_WRITE) begin
            if (it.access_size == WORD_SIZE && it.offset[1:0] == 2'b00) begin
                if (!it.clock_on) begin
                    // Gated clock: the access is taken but has no effect.
                    r.ok = 1'b1;
                end else if (it.cmd == CMD_READ) begin
                    // Input word: output mode, then external drive, then pull-up.
                    for (p = 0; p < NUM_PINS; p++) begin
                        if (mode_q[2*p +: 2] == MODE_OUTPUT)
                            idr_word[p] = odr_q[p];
                        else if (ext_drv_q[p])
                            idr_word[p] = ext_lvl_q[p];
                        else
                            idr_word[p] = (pull_q[2*p +: 2] == PULL_UP);
                    end
                    case (it.offset)
                        OFS_MODE:  rd = mode_q;
                        OFS_OTYPE: rd = {16'h0000, otype_q};
                        OFS_SPEED: rd = speed_q;
                        OFS_PULL:  rd = pull_q;
                        OFS_IDR:   rd = {16'h0000, idr_word};
                        OFS_ODR:   rd = {16'h0000, odr_q};
                        OFS_BSRR:  rd = '0;
                        OFS_LOCK:  rd = lock_q;
                        OFS_AFL:   rd = afl_q;
                        OFS_AFH:   rd = afh_q;
                        OFS_BRR:   rd = '0;
                        default:   hit = 1'b0;
                    endcase
                    r.ok = hit;
                    r.read_data = hit ? rd : 32'h0;
                end else begin
                    case (it.offset)
                        OFS_MODE:  mode_q = it.write_data;
                        OFS_OTYPE: otype_q = it.write_data[15:0];
                        OFS_SPEED: speed_q = it.write_data;
                        OFS_PULL:  pull_q = it.write_data;
                        OFS_ODR:   odr_q = it.write_data[15:0];
                        OFS_BSRR:  odr_q = (odr_q | it.write_data[15:0]) & ~it.write_data[31:16];
                        OFS_LOCK:  lock_q = it.write_data;
                        OFS_AFL:   afl_q = it.write_data;
                        OFS_AFH:   afh_q = it.write_data;
                        OFS_BRR:   odr_q = odr_q & ~it.write_data[15:0];
                        default:   hit = 1'b0;
                    endcase
                    r.ok = hit;
                end
            end
        end else if (it.cmd == CMD_PIN) begin
            // Pin events always answer ok; pins past the port are dropped.
            r.ok = 1'b1;
            if (it.pin < NUM_PINS) begin
                ext_drv_q[it.pin[3:0]] = it.pin_driven;
                ext_lvl_q[it.pin[3:0]] = it.pin_high;
            end
        end
        // Drive and level words reflect the state after this request.
        for (p = 0; p < NUM_PINS; p++)
            r.pins_driving[p] = it.clock_on && (mode_q[2*p +: 2] == MODE_OUTPUT);
        r.pins_level = odr_q;
        return r;
    endfunction

    function automatic item_t bus_request(input logic [1:0] cmd, input logic [11:0] ofs,
                                          input logic [3:0] size, input logic [31:0] data,
                                          input logic clk_on);
        item_t it;
        it = '0;
        it.cmd = cmd;
        it.offset = ofs;
        it.access_size = size;
        it.write_data = data;
        it.clock_on = clk_on;
        return it;
    endfunction

    function automatic item_t pin_request(input logic [4:0] pin, input logic drv,
                                          input logic high);
        item_t it;
        it = '0;
        it.cmd = CMD_PIN;
        it.pin = pin;
        it.pin_driven = drv;
        it.pin_high = high;
        it.clock_on = 1'b1;
        return it;
    endfunction

    // Mostly well-formed accesses to mapped registers and in-range pin events,
    // with a share of fully random requests.
    function automatic item_t random_request();
        item_t it;
        int pick;
        it.cmd = CMD_READ;
        it.offset = '0;
        it.access_size = WORD_SIZE;
        it.clock_on = ($urandom_range(0, 15) != 0);
        it.pin = 5'($urandom_range(0, 15));
        it.pin_driven = 1'($urandom_range(0, 1));
        it.pin_high = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 7))
            0:       it.write_data = 32'h0000_0000;
            1:       it.write_data = 32'hFFFF_FFFF;
            default: it.write_data = $urandom;
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            it.cmd = 2'($urandom_range(0, 3));
            it.offset = 12'($urandom_range(0, 4095));
            it.access_size = 4'($urandom_range(0, 15));
            it.clock_on = 1'($urandom_range(0, 1));
            it.pin = 5'($urandom_range(0, 31));
        end else if (pick < 35) begin
            it.cmd = CMD_PIN;
        end else begin
            it.cmd = $urandom_range(0, 1) ? CMD_WRITE : CMD_READ;
            case ($urandom_range(0, 10))
                0:       it.offset = OFS_MODE;
                1:       it.offset = OFS_OTYPE;
                2:       it.offset = OFS_SPEED;
                3:       it.offset = OFS_PULL;
                4:       it.offset = OFS_IDR;
                5:       it.offset = OFS_ODR;
                6:       it.offset = OFS_BSRR;
                7:       it.offset = OFS_LOCK;
                8:       it.offset = OFS_AFL;
                9:       it.offset = OFS_AFH;
                default: it.offset = OFS_BRR;
            endcase
        end
        return it;
    endfunction

    // Offer one request, hold it until taken and record its expected result.
    task automatic send_request(input item_t it);
        int gap;
        bit taken;
        gap = idle_on ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        req <= it;
        do begin
            @(negedge aclk);
            taken = (s_ready === 1'b1);
            if (taken)
                port_results.push_back(gpio_predict(it));
            @(posedge aclk);
        end while (!taken);
    endtask

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %h, actual %h", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Result side: random stalls, an occasional long hold-off, and a check of every result.
    initial begin : result_checker
        int stall;
        result_t got;
        result_t want;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (long_hold > 0) begin
                stall = long_hold;
                long_hold = 0;
            end else begin
                stall = idle_on ? $urandom_range(0, 6) : 0;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(negedge aclk); while (m_valid !== 1'b1);
            got.ok = m_ok;
            got.read_data = m_read_data;
            got.pins_driving = m_pins_driving;
            got.pins_level = m_pins_level;
            if (port_results.size() == 0) begin
                $error("result arrived with no request outstanding");
                mismatch_count++;
            end else begin
                want = port_results.pop_front();
                compare_field("ok", 32'(want.ok), 32'(got.ok));
                compare_field("read_data", want.read_data, got.read_data);
                compare_field("pins_driving", 32'(want.pins_driving), 32'(got.pins_driving));
                compare_field("pins_level", 32'(want.pins_level), 32'(got.pins_level));
            end
            @(posedge aclk);
        end
    end

    // Reset values, every command, the refusal rules and the pin priority order.
    task automatic test_directed_cases();
        send_request(bus_request(CMD_READ, OFS_MODE, WORD_SIZE, 32'h0, 1'b1));
        send_request(bus_request(CMD_READ, OFS_IDR, WORD_SIZE, 32'h0, 1'b1));
        // All pins pulled up, then one pin driven low from outside.
        send_request(bus_request(CMD_WRITE, OFS_PULL, WORD_SIZE, 32'h5555_5555, 1'b1));
        send_request(bus_request(CMD_READ, OFS_IDR, WORD_SIZE, 32'h0, 1'b1));
        send_request(pin_request(5'd3, 1'b1, 1'b0));
        send_request(pin_request(5'd31, 1'b1, 1'b1));
        send_request(pin_request(5'd15, 1'b1, 1'b1));
        send_request(bus_request(CMD_READ, OFS_IDR, WORD_SIZE, 32'h0, 1'b1));
        // Output mode on every pin; the upper halves of 16-bit registers are dropped.
        send_request(bus_request(CMD_WRITE, OFS_MODE, WORD_SIZE, 32'h5555_5555, 1'b1));
        send_request(bus_request(CMD_WRITE, OFS_ODR, WORD_SIZE, 32'hFFFF_FFFF, 1'b1));
        send_request(bus_request(CMD_WRITE, OFS_OTYPE, WORD_SIZE, 32'hFFFF_FFFF, 1'b1));
        send_request(bus_request(CMD_READ, OFS_OTYPE, WORD_SIZE, 32'h0, 1'b1));
        send_request(bus_request(CMD_WRITE, OFS_BSRR, WORD_SIZE, 32'h00F0_0F00, 1'b1));
        send_request(bus_request(CMD_WRITE, OFS_BRR, WORD_SIZE, 32'hFFFF_000F, 1'b1));
        send_request(bus_request(CMD_READ, OFS_IDR, WORD_SIZE, 32'h0, 1'b1));
        send_request(bus_request(CMD_READ, OFS_BSRR, WORD_SIZE, 32'h0, 1'b1));
        send_request(bus_request(CMD_READ, OFS_BRR, WORD_SIZE, 32'h0, 1'b1));
        // Refusals: read-only input word, misalignment, bad size, unmapped offset.
        send_request(bus_request(CMD_WRITE, OFS_IDR, WORD_SIZE, 32'hFFFF_FFFF, 1'b1));
        send_request(bus_request(CMD_READ, 12'h002, WORD_SIZE, 32'h0, 1'b1));
        send_request(bus_request(CMD_WRITE, OFS_ODR, 4'd8, 32'h0, 1'b1));
        send_request(bus_request(CMD_READ, 12'hFFC, WORD_SIZE, 32'h0, 1'b1));
        // Gated clock: accepted anywhere aligned, without effect.
        send_request(bus_request(CMD_READ, OFS_MODE, WORD_SIZE, 32'h0, 1'b0));
        send_request(bus_request(CMD_WRITE, OFS_ODR, WORD_SIZE, 32'h0, 1'b0));
        send_request(bus_request(CMD_READ, 12'h800, WORD_SIZE, 32'h0, 1'b0));
        send_request(bus_request(CMD_UNUSED, OFS_MODE, WORD_SIZE, 32'hFFFF_FFFF, 1'b1));
    endtask

    // Hold the result side off for a long stretch while requests keep coming.
    task automatic test_result_backpressure();
        idle_on = 1'b0;
        long_hold = 40;
        repeat (30) send_request(random_request());
        idle_on = 1'b1;
    endtask

    // Random traffic in stretches with and without idle cycles on both sides.
    task automatic test_random_traffic();
        for (int n = 0; n < 1100; n++) begin
            if (n % 80 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            send_request(random_request());
        end
        idle_on = 1'b1;
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_cases();
        test_result_backpressure();
        test_random_traffic();
        s_valid <= 1'b0;
        while (port_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Run limit, far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
